FILE: rtl/a2b_pkg.sv
// Package for the ASCII to Baudot encoder: item types, symbol codes and line tables.
package a2b_pkg;

  // Field widths
  localparam int ModeW   = 2;
  localparam int CharW   = 8;
  localparam int CodeW   = 6;
  localparam int FrameW  = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  // Most symbols one item can cause, and the matching count width
  localparam int MaxResults = 10;
  localparam int CountW     = $clog2(MaxResults + 1);

  // Command modes
  localparam logic [ModeW-1:0] ModeChar = 2'd0;
  localparam logic [ModeW-1:0] ModeInit = 2'd1;
  localparam logic [ModeW-1:0] ModeMark = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegColumnLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSkipInit    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CfgDataW-1:0] ColumnLimitReset = 8'd76;

  // Special symbol codes
  localparam logic [CodeW-1:0] SymNull   = 6'd26;
  localparam logic [CodeW-1:0] SymLf     = 6'd27;
  localparam logic [CodeW-1:0] SymSpace  = 6'd28;
  localparam logic [CodeW-1:0] SymCr     = 6'd29;
  localparam logic [CodeW-1:0] SymFigs   = 6'd30;
  localparam logic [CodeW-1:0] SymLtrs   = 6'd31;
  localparam logic [CodeW-1:0] SymClosed = 6'd33;
  localparam logic [CodeW-1:0] SymMax    = 6'd33;

  // ASCII bytes with a rule of their own
  localparam logic [CharW-1:0] AsciiLf    = 8'h0A;
  localparam logic [CharW-1:0] AsciiCr    = 8'h0D;
  localparam logic [CharW-1:0] AsciiSpace = 8'h20;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CharW-1:0] ascii_char;
  } a2b_in_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [FrameW-1:0] frame;
    logic              last;
  } a2b_out_t;

  // Line frame of a symbol: start bit, five data bits, two stop bits
  function automatic logic [FrameW-1:0] frame_of(input logic [CodeW-1:0] code);
    logic [FrameW-1:0] f;
    case (code)
      6'd0:  f = 8'h63;
      6'd1:  f = 8'h4F;
      6'd2:  f = 8'h3B;
      6'd3:  f = 8'h4B;
      6'd4:  f = 8'h43;
      6'd5:  f = 8'h5B;
      6'd6:  f = 8'h2F;
      6'd7:  f = 8'h17;
      6'd8:  f = 8'h33;
      6'd9:  f = 8'h6B;
      6'd10: f = 8'h7B;
      6'd11: f = 8'h27;
      6'd12: f = 8'h1F;
      6'd13: f = 8'h1B;
      6'd14: f = 8'h0F;
      6'd15: f = 8'h37;
      6'd16: f = 8'h77;
      6'd17: f = 8'h2B;
      6'd18: f = 8'h53;
      6'd19: f = 8'h07;
      6'd20: f = 8'h73;
      6'd21: f = 8'h3F;
      6'd22: f = 8'h67;
      6'd23: f = 8'h5F;
      6'd24: f = 8'h57;
      6'd25: f = 8'h47;
      6'd26: f = 8'h03;
      6'd27: f = 8'h23;
      6'd28: f = 8'h13;
      6'd29: f = 8'h0B;
      6'd30: f = 8'h6F;
      6'd31: f = 8'h7F;
      6'd32: f = 8'h00;
      6'd33: f = 8'hFF;
      default: f = 8'h03;
    endcase
    return f;
  endfunction

  // Figures symbol of a decimal digit, taken from the low nibble of '0'..'9'
  function automatic logic [CodeW-1:0] digit_of(input logic [3:0] d);
    logic [CodeW-1:0] s;
    case (d)
      4'd0: s = 6'd15;
      4'd1: s = 6'd16;
      4'd2: s = 6'd22;
      4'd3: s = 6'd4;
      4'd4: s = 6'd17;
      4'd5: s = 6'd19;
      4'd6: s = 6'd24;
      4'd7: s = 6'd20;
      4'd8: s = 6'd8;
      4'd9: s = 6'd14;
      default: s = SymNull;
    endcase
    return s;
  endfunction

  // Figures punctuation: {hit, symbol}
  function automatic logic [CodeW:0] punct_of(input logic [CharW-1:0] b);
    logic [CodeW:0] r;
    case (b)
      8'h2D:        r = {1'b1, 6'd0};   // '-'
      8'h3F:        r = {1'b1, 6'd1};   // '?'
      8'h3A:        r = {1'b1, 6'd2};   // ':'
      8'h24:        r = {1'b1, 6'd3};   // '$'
      8'h07:        r = {1'b1, 6'd6};   // bell
      8'h27, 8'h60: r = {1'b1, 6'd9};   // quote and backquote
      8'h28:        r = {1'b1, 6'd10};  // '('
      8'h29:        r = {1'b1, 6'd11};  // ')'
      8'h2E:        r = {1'b1, 6'd12};  // '.'
      8'h2C:        r = {1'b1, 6'd13};  // ','
      8'h3B:        r = {1'b1, 6'd21};  // ';'
      8'h2F:        r = {1'b1, 6'd23};  // '/'
      8'h22:        r = {1'b1, 6'd25};  // double quote
      default:      r = {1'b0, SymNull};
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ascii_to_baudot_encoder.sv
// ASCII to Baudot (ITA2) encoder top level with symbol queue and shift/column state.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one command item: a
//   character to encode, the line init sequence, or a run of ten mark frames.
//   Output channel (out_valid/out_ready/out_data) gives, while out_ready is
//   high, one symbol per cycle with its 8-bit line frame; last marks the final
//   symbol of an item. Configuration channel (cfg_valid/cfg_ready/cfg_index/
//   cfg_data) is always ready and writes the column limit or the init skip flag.
// Output start: the first symbol of an item is on the output in the cycle after
//   the item is accepted. An item causes 0 to 10 symbols.
// Throughput: one symbol per cycle while out_ready is high. The symbol queue
//   loads a new item in the cycle its final symbol is taken, so, with out_ready
//   high, single-symbol items flow at one per cycle.
// Reset: clears the symbol queue, the figures shift flag and column count,
//   and returns column limit to 76 and skip_init to 0.
// Stall: when out_ready is low the current symbol holds, and a new item is
//   taken only once the last queued symbol leaves.
module ascii_to_baudot_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  a2b_pkg::a2b_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output a2b_pkg::a2b_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [a2b_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [a2b_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int MaxResults = a2b_pkg::MaxResults;
  localparam int CountW     = a2b_pkg::CountW;

  // Configuration registers
  logic [a2b_pkg::CfgDataW-1:0] column_limit;
  logic                         skip_init;

  // Encoder state
  logic                     figures_shift;
  logic                     figures_shift_next;
  logic [7:0]               column_count;
  logic [7:0]               column_count_next;

  // Symbol queue, head in slot 0
  logic [a2b_pkg::CodeW-1:0] slot [MaxResults];
  logic [a2b_pkg::CodeW-1:0] slot_next [MaxResults];
  logic [CountW-1:0]         count;
  logic [CountW-1:0]         count_next;

  // Character decode
  logic [a2b_pkg::CharW-1:0] b;
  logic [a2b_pkg::CodeW:0]   punct;
  logic                      is_digit;
  logic                      is_letter;
  logic                      is_raw;
  logic                      is_print;
  logic [a2b_pkg::CodeW-1:0] head0;
  logic [a2b_pkg::CodeW-1:0] head1;
  logic                      head_two;
  logic                      char_shift;
  logic [7:0]                col_inc;
  logic                      wrap;

  logic in_accept;
  logic out_accept;

  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // Take a new item when the queue is empty or its final symbol leaves now
  assign in_ready  = (count == '0) || ((count == CountW'(1)) && out_ready);
  assign out_valid = (count != '0);
  assign cfg_ready = 1'b1;

  assign out_data.code  = slot[0];
  assign out_data.frame = a2b_pkg::frame_of(slot[0]);
  assign out_data.last  = (count == CountW'(1));

  // Classify the byte and form the leading symbols
  always_comb begin
    b         = in_data.ascii_char;
    punct     = a2b_pkg::punct_of(b);
    is_digit  = b inside {[8'h30:8'h39]};
    is_letter = b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_raw    = b inside {[8'd26:8'd33]};
    is_print  = b inside {[8'd9:8'd13], [8'd32:8'd126]};
    head0      = a2b_pkg::SymNull;
    head1      = a2b_pkg::SymNull;
    head_two   = 1'b0;
    char_shift = figures_shift;
    if (punct[a2b_pkg::CodeW] || is_digit) begin
      head1 = punct[a2b_pkg::CodeW] ? punct[a2b_pkg::CodeW-1:0] : a2b_pkg::digit_of(b[3:0]);
      if (!figures_shift) begin
        head0      = a2b_pkg::SymFigs;
        head_two   = 1'b1;
        char_shift = 1'b1;
      end else begin
        head0 = head1;
      end
    end else if (b == a2b_pkg::AsciiSpace) begin
      head0 = a2b_pkg::SymSpace;
    end else if (b == a2b_pkg::AsciiLf) begin
      head0    = a2b_pkg::SymCr;
      head1    = a2b_pkg::SymLf;
      head_two = 1'b1;
    end else if (is_letter) begin
      // 'A' and 'a' both have 1 in their low five bits
      head1 = {1'b0, b[4:0] - 5'd1};
      if (figures_shift) begin
        head0      = a2b_pkg::SymLtrs;
        head_two   = 1'b1;
        char_shift = 1'b0;
      end else begin
        head0 = head1;
      end
    end else if (is_raw) begin
      head0 = b[a2b_pkg::CodeW-1:0];
    end
    // Advance the column count and check the line limit
    col_inc = column_count;
    if (is_print) begin
      if (column_count != 8'hFF) begin
        col_inc = column_count + 8'd1;
      end
      if ((b == a2b_pkg::AsciiLf) || (b == a2b_pkg::AsciiCr)) begin
        col_inc = 8'd0;
      end
    end
    wrap = (col_inc >= column_limit);
  end

  // Build the symbol list and next state for the offered item
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      slot_next[i] = a2b_pkg::SymNull;
    end
    count_next         = '0;
    figures_shift_next = figures_shift;
    column_count_next  = column_count;
    case (in_data.mode)
      a2b_pkg::ModeChar: begin
        figures_shift_next = char_shift;
        column_count_next  = wrap ? 8'd0 : col_inc;
        slot_next[0] = head0;
        if (head_two) begin
          slot_next[1] = head1;
          if (wrap) begin
            slot_next[2] = a2b_pkg::SymCr;
            slot_next[3] = a2b_pkg::SymLf;
            slot_next[4] = a2b_pkg::SymCr;
            count_next   = CountW'(5);
          end else begin
            count_next = CountW'(2);
          end
        end else if (wrap) begin
          slot_next[1] = a2b_pkg::SymCr;
          slot_next[2] = a2b_pkg::SymLf;
          slot_next[3] = a2b_pkg::SymCr;
          count_next   = CountW'(4);
        end else begin
          count_next = CountW'(1);
        end
      end
      a2b_pkg::ModeInit: begin
        if (!skip_init) begin
          slot_next[0] = a2b_pkg::SymNull;
          slot_next[1] = a2b_pkg::SymNull;
          slot_next[2] = a2b_pkg::SymLtrs;
          slot_next[3] = a2b_pkg::SymCr;
          slot_next[4] = a2b_pkg::SymLf;
          count_next   = CountW'(5);
          figures_shift_next = 1'b0;
        end
      end
      a2b_pkg::ModeMark: begin
        for (int i = 0; i < MaxResults; i++) begin
          slot_next[i] = a2b_pkg::SymClosed;
        end
        count_next = CountW'(MaxResults);
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  // Hold configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_limit <= a2b_pkg::ColumnLimitReset;
      skip_init    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        a2b_pkg::RegColumnLimit: column_limit <= cfg_data;
        a2b_pkg::RegSkipInit:    skip_init    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Update shift flag, column count and queue fill
  always_ff @(posedge clk) begin
    if (rst) begin
      figures_shift <= 1'b0;
      column_count  <= 8'd0;
      count         <= '0;
    end else if (in_accept) begin
      figures_shift <= figures_shift_next;
      column_count  <= column_count_next;
      count         <= count_next;
    end else if (out_accept) begin
      count <= count - CountW'(1);
    end
  end

  // Load the queue on a new item, else advance it as symbols leave
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < MaxResults; i++) begin
        slot[i] <= slot_next[i];
      end
    end else if (out_accept) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        slot[i] <= slot[i + 1];
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxResults))
    else $error("symbol queue over its depth");

  a_mark_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.mode == a2b_pkg::ModeMark)
    |=> (count == CountW'(MaxResults)) && (slot[0] == a2b_pkg::SymClosed))
    else $error("mark item did not load a full run of closed symbols");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last && !in_valid |=> !out_valid)
    else $error("symbol shown after the final one of an item");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.code <= a2b_pkg::SymMax)
    else $error("symbol code out of range");
`endif

endmodule
